>>> hdl/hjd_pkg.sv
// Package for the headset jack and hook detector.
// Holds the beat structs, event and kind codes, and configuration constants.
// No dependencies.
`default_nettype none

package hjd_pkg;

    // Widths fixed by the register map.
    localparam int CFG_TICK_W = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    // Default debounce timer width.
    localparam int TIMER_BITS_DEF = 10;

    // Register reset values.
    localparam logic                  DETECT_ACTIVE_LOW_RST = 1'b1;
    localparam logic [CFG_TICK_W-1:0] JACK_TICKS_RST        = 10'd300;
    localparam logic [CFG_TICK_W-1:0] PRESS_TICKS_RST       = 10'd100;
    localparam logic [CFG_TICK_W-1:0] RELEASE_TICKS_RST     = 10'd30;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT_ACTIVE_LOW = 2'd0,
        CFG_JACK_TICKS        = 2'd1,
        CFG_PRESS_TICKS       = 2'd2,
        CFG_RELEASE_TICKS     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_MIC   = 2'd1,
        KIND_NOMIC = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        JACK_EV_NONE      = 2'd0,
        JACK_EV_INS_MIC   = 2'd1,
        JACK_EV_INS_NOMIC = 2'd2,
        JACK_EV_REMOVED   = 2'd3
    } jack_ev_t;

    typedef enum logic [1:0] {
        KEY_EV_NONE    = 2'd0,
        KEY_EV_PRESS   = 2'd1,
        KEY_EV_RELEASE = 2'd2
    } key_ev_t;

    // Current configuration as seen by the engine.
    typedef struct packed {
        logic                  detect_active_low;
        logic [CFG_TICK_W-1:0] jack_debounce_ticks;
        logic [CFG_TICK_W-1:0] press_debounce_ticks;
        logic [CFG_TICK_W-1:0] release_debounce_ticks;
    } cfg_t;

    // One tick sample.
    typedef struct packed {
        logic detect_level;
        logic hook_level;
    } sample_t;

    // One result beat.
    typedef struct packed {
        kind_t    device_kind;
        logic     mode_pin;
        jack_ev_t jack_event;
        key_ev_t  key_event;
        logic     key_down;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/hjd_cfg.sv
// Configuration register bank for the headset jack and hook detector.
// Depends on hjd_pkg.
`default_nettype none

module hjd_cfg
    import hjd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and merge the written field.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DETECT_ACTIVE_LOW: cfg_next.detect_active_low = cfg_wdata[0];
                CFG_JACK_TICKS:        cfg_next.jack_debounce_ticks = cfg_wdata;
                CFG_PRESS_TICKS:       cfg_next.press_debounce_ticks = cfg_wdata;
                CFG_RELEASE_TICKS:     cfg_next.release_debounce_ticks = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_active_low      <= DETECT_ACTIVE_LOW_RST;
            cfg_reg.jack_debounce_ticks    <= JACK_TICKS_RST;
            cfg_reg.press_debounce_ticks   <= PRESS_TICKS_RST;
            cfg_reg.release_debounce_ticks <= RELEASE_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hdl/hjd_engine.sv
// Per-tick jack and hook button decision logic with its state registers.
// Depends on hjd_pkg.
`default_nettype none

module hjd_engine
    import hjd_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire sample_t sample,
    input  wire cfg_t    cfg,
    output result_t      result
);

    localparam int CW = (TIMER_BITS > CFG_TICK_W) ? TIMER_BITS : CFG_TICK_W;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    // Window length: zero acts as one, large values saturate to the timer range.
    function automatic logic [TIMER_BITS-1:0] win_len(input logic [CFG_TICK_W-1:0] v);
        logic [CW-1:0] ve;
        logic [CW-1:0] tm;
        ve = CW'(v);
        tm = CW'(TMAX);
        if (ve == '0)
            ve = CW'(1);
        if (ve > tm)
            ve = tm;
        return ve[TIMER_BITS-1:0];
    endfunction

    kind_t                 kind_reg,      kind_next;
    logic                  boot_done_reg, boot_done_next;
    logic                  jack_pend_reg, jack_pend_next;
    logic [TIMER_BITS-1:0] jack_tmr_reg,  jack_tmr_next;
    logic                  mode_reg,      mode_next;
    logic                  btn_pend_reg,  btn_pend_next;
    logic [TIMER_BITS-1:0] btn_tmr_reg,   btn_tmr_next;
    logic                  btn_smp_reg,   btn_smp_next;
    logic                  btn_conf_reg,  btn_conf_next;
    logic                  hook_prev_reg, hook_prev_next;

    logic     present;
    logic     hook;
    logic     decide;
    jack_ev_t jack_ev;
    key_ev_t  key_ev;

    // Next state for one tick.
    always_comb
    begin
        hook           = sample.hook_level;
        present        = cfg.detect_active_low ? ~sample.detect_level : sample.detect_level;
        kind_next      = kind_reg;
        boot_done_next = 1'b1;
        jack_pend_next = jack_pend_reg;
        jack_tmr_next  = jack_tmr_reg;
        mode_next      = mode_reg;
        btn_pend_next  = btn_pend_reg;
        btn_tmr_next   = btn_tmr_reg;
        btn_smp_next   = btn_smp_reg;
        btn_conf_next  = btn_conf_reg;
        hook_prev_next = hook;
        jack_ev        = JACK_EV_NONE;
        key_ev         = KEY_EV_NONE;
        decide         = 1'b0;

        // Jack debounce, or an immediate decision on the first tick.
        if (!boot_done_reg)
        begin
            decide = 1'b1;
        end
        else if (jack_pend_reg)
        begin
            jack_tmr_next = jack_tmr_reg - 1'b1;
            if (jack_tmr_next == '0)
            begin
                jack_pend_next = 1'b0;
                if (present == (kind_reg != KIND_NONE))
                begin
                    if (kind_reg == KIND_NONE)
                        mode_next = 1'b0;
                end
                else
                begin
                    decide = 1'b1;
                end
            end
        end
        else if (present != (kind_reg != KIND_NONE))
        begin
            if (kind_reg == KIND_NONE)
                mode_next = 1'b1;
            jack_pend_next = 1'b1;
            jack_tmr_next  = win_len(cfg.jack_debounce_ticks);
        end

        // Settle the jack kind from the present pins.
        if (decide)
        begin
            if (present)
            begin
                mode_next = 1'b1;
                if (hook)
                begin
                    kind_next     = KIND_MIC;
                    btn_conf_next = 1'b1;
                    jack_ev       = JACK_EV_INS_MIC;
                end
                else
                begin
                    kind_next = KIND_NOMIC;
                    jack_ev   = JACK_EV_INS_NOMIC;
                end
            end
            else
            begin
                kind_next     = KIND_NONE;
                btn_conf_next = 1'b1;
                mode_next     = 1'b0;
                jack_ev       = JACK_EV_REMOVED;
            end
        end

        if (boot_done_reg)
        begin
            // Button window expiry.
            if (btn_pend_reg)
            begin
                btn_tmr_next = btn_tmr_reg - 1'b1;
                if (btn_tmr_next == '0)
                begin
                    btn_pend_next = 1'b0;
                    if (!jack_pend_next && kind_next == KIND_MIC &&
                        hook == btn_smp_reg && btn_conf_next != hook)
                    begin
                        btn_conf_next = hook;
                        key_ev        = hook ? KEY_EV_RELEASE : KEY_EV_PRESS;
                    end
                end
            end

            // Hook edge opens a press or release window.
            if (hook != hook_prev_reg && kind_next == KIND_MIC &&
                !btn_pend_next && !jack_pend_next)
            begin
                btn_smp_next  = hook;
                btn_pend_next = 1'b1;
                btn_tmr_next  = hook ? win_len(cfg.release_debounce_ticks)
                                     : win_len(cfg.press_debounce_ticks);
            end
        end
    end

    // Result fields for this tick.
    always_comb
    begin
        result.device_kind = kind_next;
        result.mode_pin    = mode_next;
        result.jack_event  = jack_ev;
        result.key_event   = key_ev;
        result.key_down    = ~btn_conf_next;
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_NONE;
            boot_done_reg <= 1'b0;
            jack_pend_reg <= 1'b0;
            jack_tmr_reg  <= '0;
            mode_reg      <= 1'b0;
            btn_pend_reg  <= 1'b0;
            btn_tmr_reg   <= '0;
            btn_smp_reg   <= 1'b1;
            btn_conf_reg  <= 1'b1;
            hook_prev_reg <= 1'b1;
        end
        else if (step)
        begin
            kind_reg      <= kind_next;
            boot_done_reg <= boot_done_next;
            jack_pend_reg <= jack_pend_next;
            jack_tmr_reg  <= jack_tmr_next;
            mode_reg      <= mode_next;
            btn_pend_reg  <= btn_pend_next;
            btn_tmr_reg   <= btn_tmr_next;
            btn_smp_reg   <= btn_smp_next;
            btn_conf_reg  <= btn_conf_next;
            hook_prev_reg <= hook_prev_next;
        end
    end

    // A running jack window always has ticks left.
    a_jack_tmr_live: assert property (@(posedge clk) disable iff (!rst_n)
        jack_pend_reg |-> (jack_tmr_reg != '0))
        else $error("jack window running with an empty timer");

    // A running button window always has ticks left.
    a_btn_tmr_live: assert property (@(posedge clk) disable iff (!rst_n)
        btn_pend_reg |-> (btn_tmr_reg != '0))
        else $error("button window running with an empty timer");

    // No jack or button window can open before the first tick has decided the jack.
    a_no_pend_before_boot: assert property (@(posedge clk) disable iff (!rst_n)
        !boot_done_reg |-> (!jack_pend_reg && !btn_pend_reg))
        else $error("debounce window open before first tick");

    // With no device and no window running, mic bias is off.
    a_bias_off_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg == KIND_NONE && !jack_pend_reg) |-> !mode_reg)
        else $error("mic bias driven with no device");

endmodule

`default_nettype wire

>>> hdl/headset_jack_and_hook_detector.sv
// Top level of the headset jack and hook detector.
// Depends on hjd_pkg, hjd_cfg and hjd_engine.
//
// Usage:
// - The sample channel carries one beat per 1 ms tick: the jack detect pin
//   level and the hook pin level. The result channel returns exactly one
//   beat per sample: device kind, mic bias pin level, jack event, key event
//   and the confirmed key state.
// - A sample is taken into the input register, decided by the engine and
//   written into the result register once that register is empty or its
//   beat is taken; the result is valid from the result register. Throughput
//   is one beat per cycle while the receiver takes each result, set by the
//   single decision stage between the two registers.
// - When the receiver stalls, the result register holds its beat, the input
//   register holds one more sample, and the sample channel then deasserts
//   ready until the result is taken. No beat is lost or repeated.
// - Reset clears both stages and loads the register defaults: active-low
//   detect, jack window 300 ticks, press 100, release 30. The first sample
//   after reset decides the jack at once.
// - The user must write the configuration port only while no beat is in flight (unchecked by the block).
`default_nettype none

module headset_jack_and_hook_detector
    import hjd_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_ready,
    input  wire sample_t               sample,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_t                    result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic    in_vld_reg, in_vld_next;
    sample_t in_data_reg;
    logic    res_vld_reg, res_vld_next;
    result_t res_data_reg;
    result_t eng_result;
    cfg_t    cfg;
    logic    advance;
    logic    step;

    hjd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hjd_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (in_data_reg),
        .cfg    (cfg),
        .result (eng_result)
    );

    // Pipeline flow: the result stage frees when empty or taken.
    assign advance      = !res_vld_reg || result_ready;
    assign step         = in_vld_reg && advance;
    assign sample_ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next  = sample_valid ? 1'b1 : (in_vld_reg && !advance);
        res_vld_next = advance ? in_vld_reg : res_vld_reg;
        if (!sample_ready)
            in_vld_next = in_vld_reg;
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            in_data_reg <= sample;
        if (step)
            res_data_reg <= eng_result;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_data_reg;

endmodule

`default_nettype wire
